// ----- sv/sscfp_pkg.sv -----
// Shared types, character codes and prefix tables for the scanner-scale frame parser.
package sscfp_pkg;

   localparam int FRAME_BYTES_DEF = 32;
   localparam int MAX_RESULTS     = 36;
   localparam int UPC_SYMBOLS     = 17;
   localparam int CMD_BYTES       = 4;
   localparam int GS1_BYTES       = 4;

   typedef logic [6:0] char_type;

   localparam char_type CH_NUL   = 7'h00;
   localparam char_type CH_LF    = 7'h0A;
   localparam char_type CH_CR    = 7'h0D;
   localparam char_type CH_0     = 7'h30;
   localparam char_type CH_1     = 7'h31;
   localparam char_type CH_3     = 7'h33;
   localparam char_type CH_4     = 7'h34;
   localparam char_type CH_A     = 7'h41;
   localparam char_type CH_E     = 7'h45;
   localparam char_type CH_F     = 7'h46;
   localparam char_type CH_G     = 7'h47;
   localparam char_type CH_R     = 7'h52;
   localparam char_type CH_S     = 7'h53;
   localparam char_type CH_TILDE = 7'h7E;

   typedef enum logic [1:0] {
      DEST_SCAN  = 2'd0,
      DEST_SCALE = 2'd1,
      DEST_CMD   = 2'd2
   } dest_type;

   typedef enum logic [1:0] {
      PFX_GS1   = 2'd0,
      PFX_CMD   = 2'd1,
      PFX_EMPTY = 2'd2
   } pfx_type;

   // Completed frame handed from the receive side to the sequencer.
   typedef struct packed {
      logic     go;
      char_type b1;
      char_type b2;
      char_type b3;
   } job_type;

   // One result byte leaving the sequencer.
   typedef struct packed {
      logic     vld;
      dest_type dest;
      char_type data;
      logic     empty;
      logic     last;
   } emit_type;

   function automatic char_type pfx_char(pfx_type kind, logic [1:0] cnt, char_type third);
      char_type c;
      c = CH_NUL;
      case (kind)
         PFX_GS1: begin
            case (cnt)
               2'd0:    c = CH_G;
               2'd1:    c = CH_S;
               2'd2:    c = CH_1;
               default: c = CH_TILDE;
            endcase
         end
         PFX_CMD: begin
            case (cnt)
               2'd0:    c = CH_S;
               2'd1:    c = CH_1;
               2'd2:    c = third;
               default: c = CH_CR;
            endcase
         end
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic dest_type pfx_dest(pfx_type kind);
      return (kind == PFX_CMD) ? DEST_CMD : DEST_SCAN;
   endfunction

endpackage

// ----- sv/sscfp_ram.sv -----
// Single-port-write, single-port-read character memory with registered read data.
module sscfp_ram import sscfp_pkg::*; #(
   parameter int DEPTH = FRAME_BYTES_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  char_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output char_type      rd_data
);

   char_type mem_ff [DEPTH];
   char_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sscfp_seq.sv -----
// Frame sequencer: compare/copy pass against the previous scale frame and result byte issue.
module sscfp_seq import sscfp_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   localparam int LEN_W = $clog2(FRAME_BYTES + 1),
   localparam int AW    = $clog2(FRAME_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  job_type          job,
   input  logic [LEN_W-1:0] frame_len,
   input  logic             out_free,
   input  char_type         st_rd_data,
   output logic             st_rd_en,
   output logic [AW-1:0]    st_rd_addr,
   output emit_type         emit,
   output logic             busy
);

   localparam int SCAN_END  = 4 + UPC_SYMBOLS;
   localparam int GS1_END   = 3 + MAX_RESULTS - GS1_BYTES;
   localparam int SCALE_END = MAX_RESULTS - CMD_BYTES;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CMP  = 5'b00010,
      ST_CMPW = 5'b00100,
      ST_PRE  = 5'b01000,
      ST_SPAN = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] end_ff, end_in;
   logic [LEN_W-1:0] from_ff, from_in;
   dest_type         sdest_ff, sdest_in;
   logic             span_pend_ff, span_pend_in;
   pfx_type          pfx_ff, pfx_in;
   logic [1:0]       pcnt_ff, pcnt_in;
   char_type         third_ff, third_in;
   logic             have_cmd_ff, have_cmd_in;
   logic             monitor_ff, monitor_in;
   logic             same_ff, same_in;
   logic [LEN_W-1:0] prev_len_ff, prev_len_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]    cmp_addr_ff, cmp_addr_in;

   logic             s1_vld_ff, s1_vld_in;
   logic             s1_mem_ff, s1_mem_in;
   dest_type         s1_dest_ff, s1_dest_in;
   char_type         s1_char_ff, s1_char_in;
   logic             s1_empty_ff, s1_empty_in;
   logic             s1_last_ff, s1_last_in;

   logic             issue_ok;
   logic             pv_rd_en;
   char_type         pv_rd_data;
   logic [LEN_W-1:0] body;
   logic             pfx_final;

   sscfp_ram #(.DEPTH(FRAME_BYTES)) u_prev (
      .clock   (clock),
      .wr_en   (cmp_vld_ff),
      .wr_addr (cmp_addr_ff),
      .wr_data (st_rd_data),
      .rd_en   (pv_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (pv_rd_data)
   );

   assign issue_ok   = !s1_vld_ff || out_free;
   assign body       = frame_len - LEN_W'(1);
   assign st_rd_addr = idx_ff[AW-1:0];
   assign pfx_final  = (pfx_ff == PFX_EMPTY) || (pcnt_ff == 2'd3);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      from_in      = from_ff;
      sdest_in     = sdest_ff;
      span_pend_in = span_pend_ff;
      pfx_in       = pfx_ff;
      pcnt_in      = pcnt_ff;
      third_in     = third_ff;
      have_cmd_in  = have_cmd_ff;
      monitor_in   = monitor_ff;
      prev_len_in  = prev_len_ff;
      cmp_vld_in   = 1'b0;
      cmp_addr_in  = idx_ff[AW-1:0];
      same_in      = same_ff && (!cmp_vld_ff || (st_rd_data == pv_rd_data));
      st_rd_en     = 1'b0;
      pv_rd_en     = 1'b0;

      // Output stage: drop the held byte once it moves to the output register.
      s1_vld_in   = s1_vld_ff && !out_free;
      s1_mem_in   = s1_mem_ff;
      s1_dest_in  = s1_dest_ff;
      s1_char_in  = s1_char_ff;
      s1_empty_in = s1_empty_ff;
      s1_last_in  = s1_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (job.go) begin
               pcnt_in      = 2'd0;
               span_pend_in = 1'b0;
               sdest_in     = DEST_SCAN;
               if (job.b1 == CH_0) begin
                  if (job.b3 == CH_A || job.b3 == CH_E || job.b3 == CH_F) begin
                     if (body > LEN_W'(4)) begin
                        idx_in   = LEN_W'(4);
                        end_in   = (int'(body) < SCAN_END) ? body : LEN_W'(SCAN_END);
                        state_in = ST_SPAN;
                     end else begin
                        pfx_in   = PFX_EMPTY;
                        state_in = ST_PRE;
                     end
                  end else if (job.b3 == CH_R) begin
                     pfx_in       = PFX_GS1;
                     span_pend_in = body > LEN_W'(3);
                     from_in      = LEN_W'(3);
                     end_in       = (int'(body) < GS1_END) ? body : LEN_W'(GS1_END);
                     state_in     = ST_PRE;
                  end else begin
                     pfx_in   = PFX_EMPTY;
                     state_in = ST_PRE;
                  end
               end else if (job.b1 == CH_1) begin
                  idx_in      = '0;
                  same_in     = (prev_len_ff == frame_len);
                  prev_len_in = frame_len;
                  monitor_in  = (job.b2 == CH_4);
                  have_cmd_in = (job.b2 == CH_1) || (job.b2 == CH_4);
                  third_in    = (job.b2 == CH_4 && job.b3 == CH_3) ? CH_1 : CH_4;
                  pfx_in      = PFX_CMD;
                  from_in     = '0;
                  sdest_in    = DEST_SCALE;
                  end_in      = (int'(body) < SCALE_END) ? body : LEN_W'(SCALE_END);
                  state_in    = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            // Read both stores; compare and copy in the following cycle.
            st_rd_en   = 1'b1;
            pv_rd_en   = 1'b1;
            cmp_vld_in = 1'b1;
            idx_in     = idx_ff + LEN_W'(1);
            if (idx_ff == body) begin
               state_in = ST_CMPW;
            end
         end
         ST_CMPW: begin
            span_pend_in = monitor_ff && !same_in;
            idx_in       = from_ff;
            state_in     = have_cmd_ff ? ST_PRE : ST_IDLE;
         end
         ST_PRE: begin
            if (issue_ok) begin
               s1_vld_in   = 1'b1;
               s1_mem_in   = 1'b0;
               s1_dest_in  = pfx_dest(pfx_ff);
               s1_char_in  = pfx_char(pfx_ff, pcnt_ff, third_ff);
               s1_empty_in = (pfx_ff == PFX_EMPTY);
               unique case (pfx_ff)
                  PFX_GS1:   s1_last_in = (pcnt_ff >= 2'd2) && !span_pend_ff;
                  PFX_CMD:   s1_last_in = (pcnt_ff == 2'd3);
                  default:   s1_last_in = 1'b1;
               endcase
               pcnt_in = pcnt_ff + 2'd1;
               if (pfx_final) begin
                  idx_in   = from_ff;
                  state_in = span_pend_ff ? ST_SPAN : ST_IDLE;
               end
            end
         end
         ST_SPAN: begin
            if (issue_ok) begin
               st_rd_en    = 1'b1;
               s1_vld_in   = 1'b1;
               s1_mem_in   = 1'b1;
               s1_dest_in  = sdest_ff;
               s1_empty_in = 1'b0;
               s1_last_in  = (idx_ff == end_ff - LEN_W'(1));
               idx_in      = idx_ff + LEN_W'(1);
               if (idx_ff == end_ff - LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_vld_ff   <= 1'b0;
         cmp_vld_ff  <= 1'b0;
         prev_len_ff <= '0;
      end else begin
         state_ff    <= state_in;
         s1_vld_ff   <= s1_vld_in;
         cmp_vld_ff  <= cmp_vld_in;
         prev_len_ff <= prev_len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      end_ff       <= end_in;
      from_ff      <= from_in;
      sdest_ff     <= sdest_in;
      span_pend_ff <= span_pend_in;
      pfx_ff       <= pfx_in;
      pcnt_ff      <= pcnt_in;
      third_ff     <= third_in;
      have_cmd_ff  <= have_cmd_in;
      monitor_ff   <= monitor_in;
      same_ff      <= same_in;
      cmp_addr_ff  <= cmp_addr_in;
      s1_mem_ff    <= s1_mem_in;
      s1_dest_ff   <= s1_dest_in;
      s1_char_ff   <= s1_char_in;
      s1_empty_ff  <= s1_empty_in;
      s1_last_ff   <= s1_last_in;
   end

   assign emit.vld   = s1_vld_ff;
   assign emit.dest  = s1_dest_ff;
   assign emit.data  = s1_mem_ff ? st_rd_data : s1_char_ff;
   assign emit.empty = s1_empty_ff;
   assign emit.last  = s1_last_ff;

   assign busy = (state_ff != ST_IDLE) || s1_vld_ff;

   a_job_when_idle: assert property (@(posedge clock) disable iff (reset)
      job.go |-> (state_ff == ST_IDLE) && !s1_vld_ff)
      else $error("frame handed over while sequencer busy");

   a_span_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPAN) |-> (idx_ff < end_ff) && (end_ff <= frame_len))
      else $error("span read outside the stored frame");

   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !out_free |=> s1_vld_ff && $stable(s1_char_ff) && $stable(s1_last_ff)
                                 && $stable(emit.data))
      else $error("pending result byte changed while stalled");

   a_copy_in_pass: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_CMP) || (state_ff == ST_CMPW))
      else $error("previous-frame write outside compare pass");

endmodule

// ----- sv/scanner_scale_frame_parser.sv -----
// Scanner-scale frame parser: received bytes transfer back to back, one per cycle, while
// req_ready is high. A line feed that completes a frame drops req_ready for one cycle while
// the header bytes are handed over. It then starts the sequencer, and req_ready stays low
// until the last result byte of the frame sits in the output register. Result bytes leave
// at one per cycle while rsp_ready is high. A scanner frame yields at most 32 result bytes.
// A scale frame first runs a compare-and-copy pass against the previous scale frame
// through the two frame memories, one byte per cycle. When its second byte is 1 or 4 it
// then sends the 4-byte poll command and, for a changed monitor reply, up to 31 record
// bytes. After reset the previous frame length is cleared, so the first scale frame never matches.
module scanner_scale_frame_parser import sscfp_pkg::*; #(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [6:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_destination,
   output logic [6:0] rsp_data_byte,
   output logic       rsp_empty_record,
   output logic       rsp_last
);

   localparam int LEN_W = $clog2(FRAME_BYTES + 1);
   localparam int AW    = $clog2(FRAME_BYTES);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             go_ff, go_in;
   char_type         b1_ff, b2_ff, b3_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   dest_type         rsp_dest_ff;
   char_type         rsp_data_ff;
   logic             rsp_empty_ff;
   logic             rsp_last_ff;

   logic             accept;
   logic [LEN_W-1:0] len_eff;
   logic             full;
   logic             store_we;
   logic             out_free;
   logic             busy;
   logic             st_rd_en;
   logic [AW-1:0]    st_rd_addr;
   char_type         st_rd_data;
   job_type          job;
   emit_type         emit;

   assign accept   = req_valid && req_ready;
   assign len_eff  = (req_rx_byte == CH_S) ? '0 : len_ff;
   assign full     = (len_eff == LEN_W'(FRAME_BYTES));
   assign store_we = accept && !full;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy && !go_ff;

   always_comb begin
      len_in = len_ff;
      go_in  = 1'b0;
      if (accept) begin
         len_in = len_eff;
         if (!full) begin
            len_in = len_eff + LEN_W'(1);
            go_in  = (req_rx_byte == CH_LF) && (len_eff >= LEN_W'(2));
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit.vld && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Keep the header bytes that pick the frame kind, and load the output register.
   always_ff @(posedge clock) begin
      if (store_we && len_eff == LEN_W'(1)) begin
         b1_ff <= req_rx_byte;
      end
      if (store_we && len_eff == LEN_W'(2)) begin
         b2_ff <= req_rx_byte;
      end
      if (store_we && len_eff == LEN_W'(3)) begin
         b3_ff <= req_rx_byte;
      end
      if (emit.vld && out_free) begin
         rsp_dest_ff  <= emit.dest;
         rsp_data_ff  <= emit.data;
         rsp_empty_ff <= emit.empty;
         rsp_last_ff  <= emit.last;
      end
   end

   assign job.go = go_ff;
   assign job.b1 = b1_ff;
   assign job.b2 = b2_ff;
   assign job.b3 = (len_ff > LEN_W'(3)) ? b3_ff : CH_NUL;

   sscfp_ram #(.DEPTH(FRAME_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (len_eff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   sscfp_seq #(.FRAME_BYTES(FRAME_BYTES)) u_seq (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .frame_len  (len_ff),
      .out_free   (out_free),
      .st_rd_data (st_rd_data),
      .st_rd_en   (st_rd_en),
      .st_rd_addr (st_rd_addr),
      .emit       (emit),
      .busy       (busy)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_destination  = rsp_dest_ff;
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_empty_record = rsp_empty_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
